FILE: sv/jse_pkg.sv
// shared types, character codes and defaults of the json string escaper
package jse_pkg;

    // default depth of the queue between decoder and expander
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // replacement rune for broken utf-8
    localparam logic [20:0] REPLACEMENT_RUNE = 21'h00FFFD;

    // character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_ALPHA_OFS = 8'h37;

    // one rune to be written out
    typedef struct packed {
        logic [20:0] code;  // code point, or the raw byte in simple mode
        logic        raw;   // pass through unchanged unless special
        logic        err;   // sticky error flag shown on its characters
    } rune_t;

    // one decoded input byte: up to two runes
    typedef struct packed {
        rune_t first;
        rune_t second;
        logic  has_second;
        logic  last;        // byte closed the string
    } cmd_t;

    // queue side seen by the expander
    typedef struct packed {
        cmd_t head;
        logic valid;
    } queue_out_t;

endpackage

FILE: sv/jse_front.sv
// utf-8 decoder and byte classifier feeding the expander queue
module jse_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            unicode_mode,
    output jse_pkg::cmd_t   cmd,
    output logic            cmd_valid
);

    logic [20:0] acc_reg;
    logic [20:0] acc_next;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [1:0]  slen_reg;
    logic [1:0]  slen_next;
    logic        err_reg;
    logic        err_next;

    logic        bad_a;
    logic        has_b;
    logic        b_bad;
    logic        b_raw;
    logic [20:0] b_code;
    logic        bad_c;
    logic        start_en;
    logic        seq_ok;
    logic        err_b;

    jse_pkg::rune_t rune_a;
    jse_pkg::rune_t rune_b;
    jse_pkg::rune_t rune_c;

    // decode one byte against the pending sequence
    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        slen_next = slen_reg;
        bad_a     = 1'b0;
        has_b     = 1'b0;
        b_bad     = 1'b0;
        b_raw     = 1'b0;
        b_code    = 21'd0;
        bad_c     = 1'b0;
        start_en  = 1'b0;
        seq_ok    = 1'b0;
        if (unicode_mode)
        begin
            if (pend_reg == 2'd0)
            begin
                start_en = 1'b1;
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                // interrupted sequence, byte starts afresh
                bad_a     = 1'b1;
                acc_next  = 21'd0;
                pend_next = 2'd0;
                slen_next = 2'd0;
                start_en  = 1'b1;
            end
            else
            begin
                acc_next  = {acc_reg[14:0], in_byte[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_next == 2'd0)
                begin
                    unique case (slen_reg)
                        2'd1:    seq_ok = (acc_next >= 21'h80);
                        2'd2:    seq_ok = (acc_next >= 21'h800) &&
                                          ((acc_next < 21'hD800) || (acc_next > 21'hDFFF));
                        default: seq_ok = (acc_next >= 21'h10000) && (acc_next <= 21'h10FFFF);
                    endcase
                    has_b     = 1'b1;
                    b_bad     = !seq_ok;
                    b_code    = seq_ok ? acc_next : jse_pkg::REPLACEMENT_RUNE;
                    acc_next  = 21'd0;
                    slen_next = 2'd0;
                end
            end
            // sequence start
            if (start_en)
            begin
                if (!in_byte[7])
                begin
                    has_b  = 1'b1;
                    b_code = {13'd0, in_byte};
                end
                else if (in_byte >= 8'hC2 && in_byte <= 8'hDF)
                begin
                    acc_next  = {16'd0, in_byte[4:0]};
                    pend_next = 2'd1;
                    slen_next = 2'd1;
                end
                else if (in_byte >= 8'hE0 && in_byte <= 8'hEF)
                begin
                    acc_next  = {17'd0, in_byte[3:0]};
                    pend_next = 2'd2;
                    slen_next = 2'd2;
                end
                else if (in_byte >= 8'hF0 && in_byte <= 8'hF4)
                begin
                    acc_next  = {18'd0, in_byte[2:0]};
                    pend_next = 2'd3;
                    slen_next = 2'd3;
                end
                else
                begin
                    has_b  = 1'b1;
                    b_bad  = 1'b1;
                    b_code = jse_pkg::REPLACEMENT_RUNE;
                end
            end
            // truncated end of string
            if (in_last && pend_next != 2'd0)
            begin
                bad_c     = 1'b1;
                acc_next  = 21'd0;
                pend_next = 2'd0;
                slen_next = 2'd0;
            end
        end
        else
        begin
            // simple mode drops any partial sequence
            acc_next  = 21'd0;
            pend_next = 2'd0;
            slen_next = 2'd0;
            has_b     = 1'b1;
            b_raw     = 1'b1;
            b_code    = {13'd0, in_byte};
        end
        err_next = err_reg | bad_a | b_bad | bad_c;
        if (in_last)
        begin
            acc_next  = 21'd0;
            pend_next = 2'd0;
            slen_next = 2'd0;
            err_next  = 1'b0;
        end
    end

    // build the runes in emission order
    assign err_b  = err_reg | bad_a | b_bad;
    assign rune_a = '{code: jse_pkg::REPLACEMENT_RUNE, raw: 1'b0, err: 1'b1};
    assign rune_b = '{code: b_code, raw: b_raw, err: err_b};
    assign rune_c = '{code: jse_pkg::REPLACEMENT_RUNE, raw: 1'b0, err: 1'b1};

    // pack at most two runes into one command
    always_comb
    begin
        cmd.last       = in_last;
        cmd.first      = bad_a ? rune_a : (has_b ? rune_b : rune_c);
        cmd.has_second = (bad_a && has_b) || ((bad_a || has_b) && bad_c);
        cmd.second     = (bad_a && has_b) ? rune_b : rune_c;
    end

    assign cmd_valid = bad_a | has_b | bad_c;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 21'd0;
            pend_reg <= 2'd0;
            slen_reg <= 2'd0;
            err_reg  <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            slen_reg <= slen_next;
            err_reg  <= err_next;
        end
    end

    // a closed string leaves no sequence and no error behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last) |=> (pend_reg == 2'd0 && err_reg == 1'b0))
        else $error("state not cleared after end of string");

    // a byte that ends a string always yields characters
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last) |-> cmd_valid)
        else $error("end of string produced no characters");

endmodule

FILE: sv/jse_queue.sv
// short command queue between decoder and expander
module jse_queue
#(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jse_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output logic                  full,
    output jse_pkg::queue_out_t   q_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign q_out.valid = (count_reg != '0);
    assign q_out.head  = entry_reg[rd_ptr_reg];

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !q_out.valid))
        else $error("pop from empty queue");

endmodule

FILE: sv/jse_back.sv
// expander: turns queued runes into output characters with an output register
module jse_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  jse_pkg::queue_out_t  q_out,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_char,
    output logic                 out_last,
    output logic                 string_done,
    output logic                 decode_error
);

    // escape letter of a special character, zero when not special
    function automatic logic [7:0] special_letter(input logic [20:0] code);
        logic [7:0] letter;
        letter = 8'd0;
        if (code[20:8] == 13'd0)
        begin
            unique case (code[7:0])
                8'h08:                   letter = jse_pkg::CHAR_B;
                8'h0C:                   letter = jse_pkg::CHAR_F;
                8'h0A:                   letter = jse_pkg::CHAR_N;
                8'h0D:                   letter = jse_pkg::CHAR_R;
                8'h09:                   letter = jse_pkg::CHAR_T;
                jse_pkg::CHAR_BACKSLASH: letter = jse_pkg::CHAR_BACKSLASH;
                jse_pkg::CHAR_QUOTE:     letter = jse_pkg::CHAR_QUOTE;
                default:                 letter = 8'd0;
            endcase
        end
        return letter;
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = jse_pkg::CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            ch = jse_pkg::CHAR_ALPHA_OFS + {4'd0, nib};
        end
        return ch;
    endfunction

    // number of characters a rune expands to
    function automatic logic [3:0] rune_len(input jse_pkg::rune_t r);
        logic [3:0] len;
        if (special_letter(r.code) != 8'd0)
        begin
            len = 4'd2;
        end
        else if (r.raw || (r.code >= 21'h20 && r.code <= 21'h7F))
        begin
            len = 4'd1;
        end
        else if (r.code <= 21'hFFFF)
        begin
            len = 4'd6;
        end
        else
        begin
            len = 4'd12;
        end
        return len;
    endfunction

    // character at a position of a rune's expansion
    function automatic logic [7:0] rune_char(input jse_pkg::rune_t r, input logic [3:0] pos);
        logic [7:0]  letter;
        logic [19:0] ofs;
        logic [15:0] word;
        logic [3:0]  sub;
        logic [7:0]  ch;
        letter = special_letter(r.code);
        ofs    = 20'(r.code - 21'h10000);
        if (pos < 4'd6)
        begin
            sub  = pos;
            word = (r.code <= 21'hFFFF) ? r.code[15:0] : {6'b110110, ofs[19:10]};
        end
        else
        begin
            sub  = pos - 4'd6;
            word = {6'b110111, ofs[9:0]};
        end
        if (letter != 8'd0)
        begin
            ch = (pos == 4'd0) ? jse_pkg::CHAR_BACKSLASH : letter;
        end
        else if (r.raw || (r.code >= 21'h20 && r.code <= 21'h7F))
        begin
            ch = r.code[7:0];
        end
        else
        begin
            case (sub)
                4'd0:    ch = jse_pkg::CHAR_BACKSLASH;
                4'd1:    ch = jse_pkg::CHAR_U;
                4'd2:    ch = hex_digit(word[15:12]);
                4'd3:    ch = hex_digit(word[11:8]);
                4'd4:    ch = hex_digit(word[7:4]);
                default: ch = hex_digit(word[3:0]);
            endcase
        end
        return ch;
    endfunction

    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_char_reg;
    logic           out_last_reg;
    logic           string_done_reg;
    logic           decode_error_reg;
    logic [3:0]     pos_reg;
    logic [3:0]     pos_next;
    logic           sel_reg;
    logic           sel_next;

    jse_pkg::rune_t cur_rune;
    logic [3:0]     cur_len;
    logic           final_rune;
    logic           rune_end;
    logic           cmd_end;
    logic           advance;
    logic           step;
    logic [7:0]     cur_char;

    // current rune and position within it
    assign cur_rune   = sel_reg ? q_out.head.second : q_out.head.first;
    assign cur_len    = rune_len(cur_rune);
    assign cur_char   = rune_char(cur_rune, pos_reg);
    assign final_rune = sel_reg || !q_out.head.has_second;
    assign rune_end   = (pos_reg == cur_len - 4'd1);
    assign cmd_end    = rune_end && final_rune;

    // output register accepts a new character when empty or taken
    assign advance = !out_valid_reg || out_ready;
    assign step    = advance && q_out.valid;
    assign pop     = step && cmd_end;

    always_comb
    begin
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = q_out.valid;
        end
        if (step)
        begin
            pos_next = rune_end ? 4'd0 : pos_reg + 4'd1;
            sel_next = cmd_end ? 1'b0 : (rune_end ? 1'b1 : sel_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 4'd0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            sel_reg       <= sel_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_char_reg     <= cur_char;
            out_last_reg     <= cmd_end;
            string_done_reg  <= cmd_end && q_out.head.last;
            decode_error_reg <= cur_rune.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_last     = out_last_reg;
    assign string_done  = string_done_reg;
    assign decode_error = decode_error_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && string_done_reg) |-> out_last_reg)
        else $error("string end without byte end");

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= 4'd11)
        else $error("expansion position out of range");

endmodule

FILE: sv/json_string_escaper_core.sv
// top level of the json string escaper: decoder, command queue, expander
//
//  channel   direction  signals                                         transfer when
//  in        input      in_valid in_ready in_byte in_last               in_valid && in_ready
//  out       output     out_valid out_ready out_char out_last           out_valid && out_ready
//                       string_done decode_error
//  cfg       input      cfg_valid cfg_ready cfg_data                    cfg_valid && cfg_ready
//
//  the decoder takes one byte per cycle while the queue has room; a byte that only extends
//  a utf-8 sequence yields no character; the expander writes one character per cycle while
//  out_ready is high, up to 12 per byte, so the output rate sets the sustained input rate
//  the first character of a byte passes the queue write and then the output register
//  reset clears the mode register, the decoder state, the queue and the output register
//  a stalled output fills the queue; in_ready drops only when the queue is full
module json_string_escaper_core
#(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       string_done,
    output logic       decode_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic                unicode_mode_reg;
    logic                in_fire;
    logic                queue_full;
    logic                cmd_valid;
    logic                pop;
    jse_pkg::cmd_t       cmd;
    jse_pkg::queue_out_t q_out;

    // mode register, written at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unicode_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unicode_mode_reg <= cfg_data;
        end
    end

    // input transfer
    assign in_ready = !queue_full;
    assign in_fire  = in_valid && in_ready;

    jse_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .unicode_mode (unicode_mode_reg),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid)
    );

    jse_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_fire && cmd_valid),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (queue_full),
        .q_out    (q_out)
    );

    jse_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_out        (q_out),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .out_last     (out_last),
        .string_done  (string_done),
        .decode_error (decode_error)
    );

endmodule

FILE: bench/tb_json_string_escaper_core.sv
// testbench for json_string_escaper_core: directed and random byte streams checked per character
module tb_json_string_escaper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHARS_PER_BYTE = 12;
    localparam int SETTLE_CYCLES      = 12;
    localparam int WATCHDOG_LIMIT     = 1000;
    localparam int PHASE_ITEMS        = 25;
    localparam int RANDOM_PHASES      = 6;

    localparam bit MODE_SIMPLE  = 1'b0;
    localparam bit MODE_UNICODE = 1'b1;

    // raw control bytes that get a letter escape
    localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0] BYTE_FORMFEED  = 8'h0C;
    localparam logic [7:0] BYTE_RETURN    = 8'h0D;

    // one escaped output character with its flags
    typedef struct {
        logic [7:0] ch;
        logic       byte_end;
        logic       done;
        logic       err;
    } esc_char_t;

    // expected escaped text, computed byte by byte
    class escape_scoreboard;
        bit          unicode_mode;
        logic [20:0] rune_acc;
        logic [1:0]  cont_left;
        logic [1:0]  cont_total;
        bit          err_sticky;
        esc_char_t   byte_chars[$];
        esc_char_t   escaped_text_due[$];
        int          fails;

        function new();
            unicode_mode = MODE_SIMPLE;
            clear_seq();
            err_sticky = 1'b0;
            fails = 0;
        endfunction

        function void clear_seq();
            rune_acc   = '0;
            cont_left  = '0;
            cont_total = '0;
        endfunction

        function int pending();
            return escaped_text_due.size();
        endfunction

        function void push_char(logic [7:0] c);
            esc_char_t e;
            if (byte_chars.size() >= MAX_CHARS_PER_BYTE)
                return;
            e.ch       = c;
            e.byte_end = 1'b0;
            e.done     = 1'b0;
            e.err      = err_sticky;
            byte_chars.push_back(e);
        endfunction

        function logic [7:0] escape_letter(logic [20:0] r);
            if (r > 21'h7F)
                return 8'h00;
            case (r[7:0])
                BYTE_BACKSPACE:          return jse_pkg::CHAR_B;
                BYTE_FORMFEED:           return jse_pkg::CHAR_F;
                BYTE_NEWLINE:            return jse_pkg::CHAR_N;
                BYTE_RETURN:             return jse_pkg::CHAR_R;
                BYTE_TAB:                return jse_pkg::CHAR_T;
                jse_pkg::CHAR_BACKSLASH: return jse_pkg::CHAR_BACKSLASH;
                jse_pkg::CHAR_QUOTE:     return jse_pkg::CHAR_QUOTE;
                default:                 return 8'h00;
            endcase
        endfunction

        function logic [7:0] hex_char(logic [3:0] n);
            if (n < 4'd10)
                return jse_pkg::CHAR_ZERO + {4'h0, n};
            return jse_pkg::CHAR_ALPHA_OFS + {4'h0, n};
        endfunction

        function void push_hex4(logic [15:0] v);
            push_char(jse_pkg::CHAR_BACKSLASH);
            push_char(jse_pkg::CHAR_U);
            push_char(hex_char(v[15:12]));
            push_char(hex_char(v[11:8]));
            push_char(hex_char(v[7:4]));
            push_char(hex_char(v[3:0]));
        endfunction

        // letter escape, plain ascii, \uXXXX or a surrogate pair
        function void push_rune(logic [20:0] r);
            logic [7:0]  letter;
            logic [19:0] v;
            letter = escape_letter(r);
            if (letter != 8'h00)
            begin
                push_char(jse_pkg::CHAR_BACKSLASH);
                push_char(letter);
            end
            else if (r >= 21'h20 && r <= 21'h7F)
            begin
                push_char(r[7:0]);
            end
            else if (r <= 21'hFFFF)
            begin
                push_hex4(r[15:0]);
            end
            else
            begin
                v = r[19:0] - 20'h10000;
                push_hex4(16'hD800 | {6'd0, v[19:10]});
                push_hex4(16'hDC00 | {6'd0, v[9:0]});
            end
        endfunction

        function void push_bad();
            err_sticky = 1'b1;
            push_rune(jse_pkg::REPLACEMENT_RUNE);
        endfunction

        // byte seen where a new sequence may start
        function void start_lead(logic [7:0] b);
            if (b < 8'h80)
            begin
                push_rune({13'd0, b});
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                rune_acc   = {16'd0, b[4:0]};
                cont_left  = 2'd1;
                cont_total = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                rune_acc   = {17'd0, b[3:0]};
                cont_left  = 2'd2;
                cont_total = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                rune_acc   = {18'd0, b[2:0]};
                cont_left  = 2'd3;
                cont_total = 2'd3;
            end
            else
            begin
                push_bad();
            end
        endfunction

        // utf-8 decode of one byte
        function void decode_byte(logic [7:0] b);
            logic [20:0] r;
            bit          ok;
            if (cont_left == 2'd0)
            begin
                start_lead(b);
                return;
            end
            if (b[7:6] != 2'b10)
            begin
                clear_seq();
                push_bad();
                start_lead(b);
                return;
            end
            rune_acc  = {rune_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 2'd0)
                return;
            r = rune_acc;
            if (cont_total == 2'd1)
                ok = (r >= 21'h80);
            else if (cont_total == 2'd2)
                ok = (r >= 21'h800) && (r < 21'hD800 || r > 21'hDFFF);
            else
                ok = (r >= 21'h10000) && (r <= 21'h10FFFF);
            clear_seq();
            if (ok)
                push_rune(r);
            else
                push_bad();
        endfunction

        // accepted input byte: queue the characters it causes
        function void escape_byte(logic [7:0] b, logic is_last);
            logic [7:0] letter;
            esc_char_t  tail;
            byte_chars.delete();
            if (unicode_mode)
            begin
                decode_byte(b);
                if (is_last && cont_left != 2'd0)
                begin
                    clear_seq();
                    push_bad();
                end
            end
            else
            begin
                letter = escape_letter({13'd0, b});
                clear_seq();
                if (letter != 8'h00)
                begin
                    push_char(jse_pkg::CHAR_BACKSLASH);
                    push_char(letter);
                end
                else
                begin
                    push_char(b);
                end
            end
            if (byte_chars.size() > 0)
            begin
                tail = byte_chars.pop_back();
                tail.byte_end = 1'b1;
                tail.done = is_last;
                byte_chars.push_back(tail);
            end
            if (is_last)
            begin
                clear_seq();
                err_sticky = 1'b0;
            end
            foreach (byte_chars[i])
                escaped_text_due.push_back(byte_chars[i]);
        endfunction

        // accepted output character against the oldest expectation
        function void check_char(logic [7:0] c, logic lst, logic done, logic err);
            esc_char_t want;
            if (escaped_text_due.size() == 0)
            begin
                fails++;
                $display("%0t: expected no character, got char=%h last=%b done=%b err=%b",
                         $time, c, lst, done, err);
                return;
            end
            want = escaped_text_due.pop_front();
            if ({c, lst, done, err} !== {want.ch, want.byte_end, want.done, want.err})
            begin
                fails++;
                $display({"%0t: expected char=%h last=%b done=%b err=%b,",
                          " got char=%h last=%b done=%b err=%b"},
                         $time, want.ch, want.byte_end, want.done, want.err,
                         c, lst, done, err);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte      = 8'h00;
    logic       in_last      = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] out_char;
    logic       out_last;
    logic       string_done;
    logic       decode_error;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_data     = 1'b0;

    escape_scoreboard sb = new();

    logic [7:0] seq_bytes[$];
    int         items_sent = 0;
    bit         gap_free = 1'b0;
    int         ready_left = 0;
    bit         ready_on = 1'b0;
    int         idle_cycles = 0;

    logic [7:0] simple_probe[9] = '{8'h00, BYTE_BACKSPACE, BYTE_TAB, BYTE_NEWLINE, BYTE_FORMFEED,
                                   BYTE_RETURN, jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_BACKSLASH,
                                   8'hFF};
    logic [7:0] unicode_probe[16] = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80,
                                     8'hED, 8'hA0, 8'h80, 8'hF5, 8'hC2, 8'h41, 8'hE2, 8'h82};
    bit         unicode_probe_last[16] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    bit         phase_mode[RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    json_string_escaper_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .out_last     (out_last),
        .string_done  (string_done),
        .decode_error (decode_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls: short and long, with long stretches of steady ready
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_on = !ready_on;
            if (ready_on)
                ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 10);
            else
                ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
        ready_left = ready_left - 1;
        out_ready <= ready_on;
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(out_char, out_last, string_done, decode_error);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("json_string_escaper_core: mismatch");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int k;
        if (gap_free)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte transfer on the input channel
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if ($urandom_range(0, 24) == 0)
            gap_free = !gap_free;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.escape_byte(b, is_last);
        items_sent++;
    endtask

    // hold input until every expected character is out and the queue is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mode register write, only while idle
    task automatic set_mode(input bit m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.unicode_mode = m;
    endtask

    function automatic void encode_rune(logic [20:0] r, int n);
        case (n)
            1: seq_bytes.push_back(r[7:0]);
            2:
            begin
                seq_bytes.push_back({3'b110, r[10:6]});
                seq_bytes.push_back({2'b10, r[5:0]});
            end
            3:
            begin
                seq_bytes.push_back({4'b1110, r[15:12]});
                seq_bytes.push_back({2'b10, r[11:6]});
                seq_bytes.push_back({2'b10, r[5:0]});
            end
            default:
            begin
                seq_bytes.push_back({5'b11110, r[20:18]});
                seq_bytes.push_back({2'b10, r[17:12]});
                seq_bytes.push_back({2'b10, r[11:6]});
                seq_bytes.push_back({2'b10, r[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] valid_rune(int n);
        logic [20:0] r;
        case (n)
            1: r = 21'($urandom_range(0, 'h7F));
            2: r = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                r = 21'($urandom_range('h800, 'hFFFF));
                if (r >= 21'hD800 && r <= 21'hDFFF)
                    r = r ^ 21'h8000;
            end
            default: r = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 7))
            0: return BYTE_BACKSPACE;
            1: return BYTE_TAB;
            2: return BYTE_NEWLINE;
            3: return BYTE_FORMFEED;
            4: return BYTE_RETURN;
            5: return jse_pkg::CHAR_QUOTE;
            6: return jse_pkg::CHAR_BACKSLASH;
            default: return 8'($urandom_range(0, 'h1F));
        endcase
    endfunction

    // mostly well-formed utf-8 runes, some broken or noise
    function automatic void queue_unicode_item();
        int          k;
        int          n;
        logic [20:0] r;
        k = $urandom_range(0, 99);
        if (k < 30)
        begin
            encode_rune(valid_rune(1), 1);
        end
        else if (k < 38)
        begin
            seq_bytes.push_back(pick_special());
        end
        else if (k < 72)
        begin
            n = (k < 50) ? 2 : (k < 62) ? 3 : 4;
            encode_rune(valid_rune(n), n);
        end
        else if (k < 76)
        begin
            // overlong form
            n = $urandom_range(2, 4);
            r = 21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
            encode_rune(r, n);
        end
        else if (k < 80)
        begin
            encode_rune(21'($urandom_range('hD800, 'hDFFF)), 3);
        end
        else if (k < 84)
        begin
            encode_rune(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end
        else if (k < 90)
        begin
            // truncated sequence
            n = $urandom_range(2, 4);
            encode_rune(valid_rune(n), n);
            repeat ($urandom_range(1, n - 1))
                void'(seq_bytes.pop_back());
        end
        else if (k < 95)
        begin
            seq_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                                     : 8'($urandom_range('hF5, 'hFF)));
        end
        else
        begin
            seq_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_seq();
        int n;
        bit is_last;
        n = seq_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                is_last = ($urandom_range(0, 5) == 0);
            else
                is_last = ($urandom_range(0, 40) == 0);
            send_byte(seq_bytes[i], is_last);
        end
        seq_bytes.delete();
    endtask

    // one random phase in a fixed mode
    task automatic run_random_phase(input bit m, input bit with_pause);
        int start;
        bit paused;
        start  = items_sent;
        paused = 1'b0;
        set_mode(m);
        while (items_sent - start < PHASE_ITEMS)
        begin
            if (with_pause && !paused && items_sent - start >= PHASE_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if (m == MODE_UNICODE)
                queue_unicode_item();
            else if ($urandom_range(0, 99) < 30)
                seq_bytes.push_back(pick_special());
            else
                seq_bytes.push_back(8'($urandom_range(0, 255)));
            send_seq();
        end
        drain_results();
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // simple mode: extremes and every special
        set_mode(MODE_SIMPLE);
        foreach (simple_probe[i])
            send_byte(simple_probe[i], i == 8);
        drain_results();

        // unicode mode: control, 0x7f, 2- and 4-byte runes, surrogate, bad lead,
        // interrupted and truncated sequences
        set_mode(MODE_UNICODE);
        foreach (unicode_probe[i])
            send_byte(unicode_probe[i], unicode_probe_last[i]);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(phase_mode[p], p == 2);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("json_string_escaper_core: match");
        else
            $display("json_string_escaper_core: mismatch");
        $finish;
    end

endmodule
